### rtl/hpd_pkg.sv
// Shared types and constants of the Huffman packet decoder.
// No dependencies; hpd_obuf and the decoder core import this package.
package hpd_pkg;

    localparam int MAX_NODES_DEF = 128;

    localparam int BYTE_W  = 8;
    localparam int ENTRY_W = 25;
    localparam int CNT_W   = 8;
    localparam int BITS_W  = 16;

    // Node entry layout: leaf flag, symbol (left-given flag on internal nodes),
    // left child, right child.
    localparam int LEAF_BIT      = 24;
    localparam int LEFT_DONE_BIT = 16;

    localparam logic [BYTE_W-1:0] CH_EMPTY    = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_INTERNAL = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_BAD      = 8'h3F;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TREE,
        PH_PAYLOAD,
        PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TREE_UPD,
        ST_POP_RD,
        ST_WALK,
        ST_WAIT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] symbol;
        logic              bad_code;
        logic              tree_error;
    } t_result;

endpackage

### rtl/hpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hpd_obuf.sv
// Result staging: one pending result plus the output register.
// Depends on hpd_pkg (t_result).
module hpd_obuf
    import hpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_res,
    input  logic    i_flush,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_last,
    input  logic    i_out_ready
);

    logic    r_pend_v;
    t_result r_pend;
    logic    r_out_v;
    t_result r_out;
    logic    r_out_last;
    logic    out_free;

    assign out_free = !r_out_v || i_out_ready;
    assign o_ready  = !r_pend_v || out_free;

    // A pending result learns it is not the last when another one arrives,
    // and that it is the last on flush.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (r_pend_v && out_free && (i_push || i_flush)) begin
                r_out      <= r_pend;
                r_out_last <= !i_push;
                r_out_v    <= 1'b1;
                r_pend_v   <= 1'b0;
            end
            if (i_push) begin
                r_pend   <= i_push_res;
                r_pend_v <= 1'b1;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_last  = r_out_last;

endmodule

### rtl/huffman_packet_decoder_core.sv
// Huffman packet decoder: header, preorder tree build, LSB-first bit walk.
// Header byte: ST_IDLE then ST_DISPATCH; a tree byte adds a node-table read-modify-write
// (ST_TREE_UPD) and a stack read on pop (ST_POP_RD). A payload byte steps its bits through
// ST_WALK and ST_WAIT, reading the node table for each child reached; receiver stalls hold the walk.
// Results leave through a one-deep pending stage and an output register.
// Synchronous reset clears control state only; memory entries are written before read.
module huffman_packet_decoder_core
    import hpd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] packet_byte
    input  logic        i_s_axis_tuser,   // [0] first
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] symbol
    output logic [1:0]  o_m_axis_tuser,   // [0] bad_code, [1] tree_error
    output logic        o_m_axis_tlast
);

    localparam int AW = $clog2(MAX_NODES);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_NODES);

    // Control state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [1:0]          r_hc, n_hc;
    logic [BITS_W-1:0]   r_total, n_total;
    logic [BITS_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]    r_node_cnt, n_node_cnt;
    logic [CNT_W-1:0]    r_depth, n_depth;
    logic                r_at_root, n_at_root;
    logic                r_open, n_open;
    logic [3:0]          r_bit, n_bit;
    // Datapath registers
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [CNT_W-1:0]    r_top, n_top;
    logic [ENTRY_W-1:0]  r_root, n_root;
    logic [ENTRY_W-1:0]  r_cur, n_cur;
    logic [CNT_W-1:0]    r_child, n_child;
    logic                r_int, n_int;

    // Memory ports
    logic                nt_we, nt_re;
    logic [AW-1:0]       nt_waddr, nt_raddr;
    logic [ENTRY_W-1:0]  nt_wdata, nt_rdata;
    logic                st_we, st_re;
    logic [AW-1:0]       st_waddr, st_raddr;
    logic [CNT_W-1:0]    st_wdata, st_rdata;

    // Result staging
    logic                obuf_push, obuf_flush, obuf_ready;
    t_result             obuf_res, out_res;

    // Combinational helpers
    logic                in_acc;
    logic                do_step;
    logic                step_bit, step_skip, step_bad;
    logic [ENTRY_W-1:0]  step_src;
    logic [CNT_W-1:0]    step_child;
    logic                alloc, internal;
    logic [ENTRY_W-1:0]  new_entry, upd;
    logic                pop;
    logic [CNT_W-1:0]    depth_after, depth_m1;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);

    hpd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nt_we),
        .i_waddr (nt_waddr),
        .i_wdata (nt_wdata),
        .i_re    (nt_re),
        .i_raddr (nt_raddr),
        .o_rdata (nt_rdata)
    );

    hpd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    hpd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (obuf_push),
        .i_push_res  (obuf_res),
        .i_flush     (obuf_flush),
        .o_ready     (obuf_ready),
        .o_valid     (o_m_axis_tvalid),
        .o_res       (out_res),
        .o_last      (o_m_axis_tlast),
        .i_out_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = out_res.symbol;
    assign o_m_axis_tuser = {out_res.tree_error, out_res.bad_code};

    // One code bit: pick the child of the current node (left on 0, right on 1).
    // In ST_WAIT the current node is the entry just read from the node table.
    always_comb begin
        step_bit   = r_byte[r_bit[2:0]];
        step_src   = (r_state == ST_WAIT) ? nt_rdata : (r_at_root ? r_root : r_cur);
        step_child = step_bit ? step_src[7:0] : step_src[15:8];
        step_bad   = (step_child == '0) || (step_child >= r_node_cnt) ||
                     (step_child >= MAX_C);
        step_skip  = !r_open && (r_used >= r_total);
    end

    // Tree byte decode
    always_comb begin
        internal = (r_byte == CH_INTERNAL);
        alloc    = (r_byte != CH_EMPTY) || (r_node_cnt == '0);
        if (internal) begin
            new_entry = '0;
        end else if (r_byte == CH_EMPTY) begin
            new_entry = {1'b1, 24'd0};
        end else begin
            new_entry = {1'b1, r_byte, 16'd0};
        end
    end

    // Attach a child to the node on top of the stack; pop once both are given.
    always_comb begin
        pop = nt_rdata[LEFT_DONE_BIT];
        if (!pop) begin
            upd = nt_rdata | (ENTRY_W'(1) << LEFT_DONE_BIT) | {9'd0, r_child, 8'd0};
        end else begin
            upd = nt_rdata | {17'd0, r_child};
        end
        depth_after = r_depth - {{(CNT_W-1){1'b0}}, pop};
        depth_m1    = depth_after - CNT_W'(1);
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_hc       = r_hc;
        n_total    = r_total;
        n_used     = r_used;
        n_node_cnt = r_node_cnt;
        n_depth    = r_depth;
        n_at_root  = r_at_root;
        n_open     = r_open;
        n_bit      = r_bit;
        n_byte     = r_byte;
        n_top      = r_top;
        n_root     = r_root;
        n_cur      = r_cur;
        n_child    = r_child;
        n_int      = r_int;
        nt_we      = 1'b0;
        nt_waddr   = '0;
        nt_wdata   = '0;
        nt_re      = 1'b0;
        nt_raddr   = '0;
        st_we      = 1'b0;
        st_waddr   = '0;
        st_wdata   = '0;
        st_re      = 1'b0;
        st_raddr   = '0;
        obuf_push  = 1'b0;
        obuf_res   = '0;
        obuf_flush = 1'b0;
        do_step    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_byte  = i_s_axis_tdata;
                    n_state = ST_DISPATCH;
                    // first byte of a packet: drop all parsing state
                    if (i_s_axis_tuser) begin
                        n_phase    = PH_HEADER;
                        n_hc       = '0;
                        n_total    = '0;
                        n_used     = '0;
                        n_node_cnt = '0;
                        n_depth    = '0;
                        n_at_root  = 1'b1;
                        n_open     = 1'b0;
                    end
                end
            end

            ST_DISPATCH: begin
                n_state = ST_IDLE;
                unique case (r_phase)
                    PH_HEADER: begin
                        if (r_hc == 2'd1) begin
                            n_total = {r_byte, 8'd0};
                        end else if (r_hc == 2'd2) begin
                            n_total = {r_total[15:8], r_byte};
                            n_phase = PH_TREE;
                        end
                        n_hc = r_hc + 2'd1;
                    end
                    PH_TREE: begin
                        if (alloc) begin
                            if ((r_node_cnt >= MAX_C) || (r_depth >= MAX_C)) begin
                                // table full: one error result, then halt
                                n_phase             = PH_HALT;
                                obuf_push           = 1'b1;
                                obuf_res.tree_error = 1'b1;
                                n_state             = ST_FLUSH;
                            end else begin
                                nt_we      = 1'b1;
                                nt_waddr   = r_node_cnt[AW-1:0];
                                nt_wdata   = new_entry;
                                n_node_cnt = r_node_cnt + CNT_W'(1);
                                if (r_node_cnt == '0) begin
                                    if (internal) begin
                                        st_we    = 1'b1;
                                        st_waddr = r_depth[AW-1:0];
                                        st_wdata = '0;
                                        n_depth  = r_depth + CNT_W'(1);
                                        n_top    = '0;
                                    end else begin
                                        n_phase = PH_PAYLOAD;
                                    end
                                end else if (r_depth == '0) begin
                                    n_phase = PH_PAYLOAD;
                                end else begin
                                    n_child  = r_node_cnt;
                                    n_int    = internal;
                                    nt_re    = 1'b1;
                                    nt_raddr = r_top[AW-1:0];
                                    n_state  = ST_TREE_UPD;
                                end
                            end
                        end else if (r_depth == '0) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            // empty child: attach index zero
                            n_child  = '0;
                            n_int    = 1'b0;
                            nt_re    = 1'b1;
                            nt_raddr = r_top[AW-1:0];
                            n_state  = ST_TREE_UPD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_bit   = '0;
                        n_state = ST_WALK;
                    end
                    PH_HALT: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end

            ST_TREE_UPD: begin
                nt_we    = 1'b1;
                nt_waddr = r_top[AW-1:0];
                nt_wdata = upd;
                n_state  = ST_IDLE;
                if (r_int && (r_child != '0)) begin
                    st_we    = 1'b1;
                    st_waddr = depth_after[AW-1:0];
                    st_wdata = r_child;
                    n_depth  = depth_after + CNT_W'(1);
                    n_top    = r_child;
                end else begin
                    n_depth = depth_after;
                    if (depth_after == '0) begin
                        n_phase = PH_PAYLOAD;
                    end else if (pop) begin
                        // fetch the new top of stack
                        st_re    = 1'b1;
                        st_raddr = depth_m1[AW-1:0];
                        n_state  = ST_POP_RD;
                    end
                end
            end

            ST_POP_RD: begin
                n_top   = st_rdata;
                n_state = ST_IDLE;
            end

            ST_WALK: begin
                do_step = obuf_ready;
            end

            ST_WAIT: begin
                if (obuf_ready) begin
                    if (nt_rdata[LEAF_BIT]) begin
                        obuf_push       = 1'b1;
                        obuf_res.symbol = nt_rdata[23:16];
                        n_open          = 1'b0;
                        n_at_root       = 1'b1;
                        n_state         = r_bit[3] ? ST_FLUSH : ST_WALK;
                    end else begin
                        // internal node: descend and take the next bit at once
                        n_cur     = nt_rdata;
                        n_at_root = 1'b0;
                        if (r_bit[3]) begin
                            n_state = ST_FLUSH;
                        end else begin
                            do_step = 1'b1;
                        end
                    end
                end
            end

            ST_FLUSH: begin
                obuf_flush = 1'b1;
                if (obuf_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (do_step) begin
            n_bit   = r_bit + 4'd1;
            n_state = (r_bit == 4'd7) ? ST_FLUSH : ST_WALK;
            if (!step_skip) begin
                n_open = 1'b1;
                if (r_used != '1) begin
                    n_used = r_used + BITS_W'(1);
                end
                if (step_bad) begin
                    obuf_push         = 1'b1;
                    obuf_res.symbol   = CH_BAD;
                    obuf_res.bad_code = 1'b1;
                    n_open            = 1'b0;
                    n_at_root         = 1'b1;
                end else begin
                    nt_re    = 1'b1;
                    nt_raddr = step_child[AW-1:0];
                    n_state  = ST_WAIT;
                end
            end
        end

        // shadow copy of the root entry, so a walk restarts without a read
        if (nt_we && (nt_waddr == '0)) begin
            n_root = nt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_HEADER;
            r_hc       <= '0;
            r_total    <= '0;
            r_used     <= '0;
            r_node_cnt <= '0;
            r_depth    <= '0;
            r_at_root  <= 1'b1;
            r_open     <= 1'b0;
            r_bit      <= '0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_hc       <= n_hc;
            r_total    <= n_total;
            r_used     <= n_used;
            r_node_cnt <= n_node_cnt;
            r_depth    <= n_depth;
            r_at_root  <= n_at_root;
            r_open     <= n_open;
            r_bit      <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_top   <= n_top;
        r_root  <= n_root;
        r_cur   <= n_cur;
        r_child <= n_child;
        r_int   <= n_int;
    end

    // The stack holds only allocated nodes.
    a_depth_le_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_node_cnt)
        else $error("stack deeper than node count");

    a_nodes_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_cnt <= MAX_C)
        else $error("node count beyond table size");

    a_wait_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WAIT |-> $past(r_state) == ST_WALK || $past(r_state) == ST_WAIT)
        else $error("node read wait entered outside the bit walk");

    a_push_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        obuf_push |-> obuf_ready)
        else $error("result pushed into a full staging buffer");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tlast)
        else $error("tree error word not marked last");

endmodule
